>>> sv/tgard_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgard_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_COMPRESSED  = 2'd0;
	localparam logic [1:0] CFG_FOUR_BPP    = 2'd1;
	localparam logic [1:0] CFG_PIXEL_TOTAL = 2'd2;

	localparam logic         COMPRESSED_RST  = 1'b1;
	localparam logic         FOUR_BPP_RST    = 1'b0;
	localparam logic [24:0]  PIXEL_TOTAL_RST = 25'd65536;

	localparam logic [7:0] RUN_BIAS    = 8'd127;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Byte request held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} tgard_s1_t;

endpackage

>>> sv/tgard_in_stage.sv
// Input register stage: holds one accepted byte request until the decoder takes it.
module tgard_in_stage import tgard_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       adv,
	output tgard_s1_t  req_s1
);

	logic       valid_s1;
	logic [7:0] data_s1;

	assign in_stall = valid_s1 && !adv;
	assign req_s1   = '{valid: valid_s1, data: data_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
		end
	end

endmodule

>>> sv/tgard_core.sv
// Decoder core: configuration, packet and pixel state, and the result register.
module tgard_core import tgard_pkg::*; #(
	parameter longint unsigned MAX_PIXELS = 64'd16777216
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  tgard_s1_t   req_s1,
	output logic        adv,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  repeat_count,
	output logic        image_done
);

	localparam int REM_W = (MAX_PIXELS >= 64'd33554431) ? 25 : $clog2(MAX_PIXELS + 64'd1);

	function automatic logic [REM_W-1:0] sat_total(input logic [24:0] v);
		if (64'(v) > MAX_PIXELS)
			return REM_W'(MAX_PIXELS);
		else
			return REM_W'(v);
	endfunction

	logic             compressed_q, four_q;
	logic [24:0]      pixel_total_q;
	logic             await_q, run_q;
	logic [7:0]       left_q;
	logic [1:0]       slot_q;
	logic [23:0]      held_q;
	logic [REM_W-1:0] rem_q;

	logic             await_n, run_n;
	logic [7:0]       left_n;
	logic [1:0]       slot_n;
	logic [23:0]      held_n;
	logic [REM_W-1:0] rem_n;

	logic             restart, fire, emit;
	logic [1:0]       last_slot;
	logic [7:0]       b, rep, rep_c;
	logic [24:0]      total_src;

	logic             out_valid_q, done_q;
	logic [7:0]       red_q, green_q, blue_q, alpha_q, rep_q;

	assign restart = cfg_we && (cfg_index == CFG_COMPRESSED || cfg_index == CFG_FOUR_BPP ||
		cfg_index == CFG_PIXEL_TOTAL);
	assign total_src = (cfg_index == CFG_PIXEL_TOTAL) ? cfg_data : pixel_total_q;
	assign adv       = !out_valid_q || !out_stall;
	assign fire      = req_s1.valid && adv;
	assign b         = req_s1.data;
	assign last_slot = four_q ? 2'd3 : 2'd2;

	always_comb begin
		await_n = await_q;
		run_n   = run_q;
		left_n  = left_q;
		slot_n  = slot_q;
		held_n  = held_q;
		rem_n   = rem_q;
		emit    = 1'b0;
		rep     = 8'd1;
		rep_c   = 8'd1;
		if (fire && rem_q != '0) begin
			if (compressed_q && await_q) begin
				run_n   = b[7];
				left_n  = b[7] ? (b - RUN_BIAS) : (b + 8'd1);
				await_n = 1'b0;
				slot_n  = 2'd0;
			end else if (slot_q < last_slot) begin
				case (slot_q)
					2'd0: begin
						held_n[7:0] = b;
					end
					2'd1: begin
						held_n[15:8] = b;
					end
					default: begin
						held_n[23:16] = b;
					end
				endcase
				slot_n = slot_q + 2'd1;
			end else begin
				emit   = 1'b1;
				slot_n = 2'd0;
				if (compressed_q) begin
					if (run_q) begin
						rep    = left_q;
						left_n = 8'd0;
					end else if (left_q != 8'd0) begin
						left_n = left_q - 8'd1;
					end
					if (left_n == 8'd0)
						await_n = 1'b1;
				end
				// clip the run at the image end
				rep_c = (25'(rep) > 25'(rem_q)) ? 8'(rem_q) : rep;
				rem_n = rem_q - REM_W'(rep_c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_q  <= COMPRESSED_RST;
			four_q        <= FOUR_BPP_RST;
			pixel_total_q <= PIXEL_TOTAL_RST;
			await_q       <= 1'b1;
			run_q         <= 1'b0;
			left_q        <= 8'd0;
			slot_q        <= 2'd0;
			held_q        <= 24'd0;
			rem_q         <= sat_total(PIXEL_TOTAL_RST);
		end else if (restart) begin
			if (cfg_index == CFG_COMPRESSED)
				compressed_q <= cfg_data[0];
			if (cfg_index == CFG_FOUR_BPP)
				four_q <= cfg_data[0];
			if (cfg_index == CFG_PIXEL_TOTAL)
				pixel_total_q <= cfg_data;
			await_q <= 1'b1;
			run_q   <= 1'b0;
			left_q  <= 8'd0;
			slot_q  <= 2'd0;
			held_q  <= 24'd0;
			rem_q   <= sat_total(total_src);
		end else begin
			await_q <= await_n;
			run_q   <= run_n;
			left_q  <= left_n;
			slot_q  <= slot_n;
			held_q  <= held_n;
			rem_q   <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// stored order is B, G, R(, A)
	always_ff @(posedge clk) begin
		if (emit) begin
			blue_q  <= held_q[7:0];
			green_q <= held_q[15:8];
			red_q   <= four_q ? held_q[23:16] : b;
			alpha_q <= four_q ? b : ALPHA_OPAQUE;
			rep_q   <= rep_c;
			done_q  <= (rem_n == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign alpha        = alpha_q;
	assign repeat_count = rep_q;
	assign image_done   = done_q;

	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (rep_q != 8'd0 && rep_q <= 8'd128))
		else $error("repeat count out of range");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == '0 && !restart) |=> (rem_q == '0))
		else $error("pixel count moved after image end");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!four_q |-> (slot_q <= 2'd2))
		else $error("channel slot past last BGR byte");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && rem_n == '0 && !restart) |=> (out_valid_q && image_done && rem_q == '0))
		else $error("image end not flagged");

endmodule

>>> sv/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
// One pixel-data byte request is accepted per cycle unless the input is stalled; each
// byte passes an input register and the decode logic into a result register. Input
// stalls only while the result register holds a pixel that the output side is stalling.
// A write to one of the three configuration registers restarts decoding of a fresh image.
module tga_rle_pixel_decoder import tgard_pkg::*; #(
	parameter longint unsigned MAX_PIXELS = 64'd16777216
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  repeat_count,
	output logic        image_done
);

	tgard_s1_t req_s1;
	logic      adv;

	tgard_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.adv       (adv),
		.req_s1    (req_s1)
	);

	tgard_core #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_s1       (req_s1),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.repeat_count (repeat_count),
		.image_done   (image_done)
	);

endmodule

>>> tb/sv/tga_rle_pixel_decoder_tb.sv
// Self-checking testbench for the TGA run-length pixel decoder.
module tga_rle_pixel_decoder_tb;
	import tgard_pkg::*;

	localparam logic [1:0]  CFG_UNUSED      = 2'd3;
	localparam logic [24:0] MAX_PIXEL_COUNT = 25'd16777216;
	localparam int          RANDOM_ITEMS    = 1500;
	localparam int          SETTLE_CYCLES   = 4;
	localparam int          WATCHDOG_LIMIT  = 600;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] span;
		logic       done;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [24:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_count;
	logic        image_done;

	tga_rle_pixel_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.repeat_count (repeat_count),
		.image_done   (image_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as the testbench sees it
	logic        cfg_compressed;
	logic        cfg_four_bpp;
	logic [24:0] cfg_pixel_total;
	logic        want_header;
	logic        in_run;
	logic [7:0]  packet_left;
	logic [1:0]  byte_slot;
	logic [23:0] bgr_hold;
	logic [24:0] image_left;

	pixel_t pending_pixels[$];

	int mismatch_count = 0;
	int pixels_checked = 0;
	int live_bytes     = 0;
	int reg_writes     = 0;
	int quiet_cycles   = 0;

	int gap_pct   = 0;
	int gap_max   = 1;
	int stall_pct = 0;
	int stall_max = 1;
	int stall_hold = 0;

	function automatic void restart_image();
		image_left  = (cfg_pixel_total > MAX_PIXEL_COUNT) ? MAX_PIXEL_COUNT : cfg_pixel_total;
		want_header = 1'b1;
		in_run      = 1'b0;
		packet_left = '0;
		byte_slot   = '0;
		bgr_hold    = '0;
	endfunction

	function automatic void apply_reg(input logic [1:0] index, input logic [24:0] value);
		case (index)
			CFG_COMPRESSED:  cfg_compressed  = value[0];
			CFG_FOUR_BPP:    cfg_four_bpp    = value[0];
			CFG_PIXEL_TOTAL: cfg_pixel_total = value;
			default:         return;
		endcase
		restart_image();
	endfunction

	// Work out what one accepted byte does to the decoder, queueing any pixel it completes
	function automatic void decode_byte(input logic [7:0] b);
		pixel_t     px;
		logic [1:0] last_slot;
		logic [7:0] span;
		last_slot = cfg_four_bpp ? 2'd3 : 2'd2;
		if (image_left == 0)
			return;
		if (cfg_compressed && want_header) begin
			in_run      = b[7];
			packet_left = b[7] ? b - RUN_BIAS : b + 8'd1;
			want_header = 1'b0;
			byte_slot   = '0;
			return;
		end
		if (byte_slot < last_slot) begin
			bgr_hold[byte_slot * 8 +: 8] = b;
			byte_slot = byte_slot + 2'd1;
			return;
		end
		px.blue  = bgr_hold[7:0];
		px.green = bgr_hold[15:8];
		if (cfg_four_bpp) begin
			px.red   = bgr_hold[23:16];
			px.alpha = b;
		end else begin
			px.red   = b;
			px.alpha = ALPHA_OPAQUE;
		end
		byte_slot = '0;
		span = 8'd1;
		if (cfg_compressed) begin
			if (in_run) begin
				span        = packet_left;
				packet_left = '0;
			end else if (packet_left != 0) begin
				packet_left = packet_left - 8'd1;
			end
			if (packet_left == 0)
				want_header = 1'b1;
		end
		if (span > image_left)
			span = image_left[7:0];
		image_left = image_left - span;
		px.span = span;
		px.done = (image_left == 0);
		pending_pixels.push_back(px);
	endfunction

	function automatic logic [24:0] noisy_flag(input logic bit_value);
		logic [24:0] v;
		v    = 25'($urandom);
		v[0] = bit_value;
		return v;
	endfunction

	function automatic void add_random_pixel(ref byte_q_t q, input logic four);
		repeat (four ? 4 : 3) q.push_back(8'($urandom_range(255)));
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 30)
			$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [24:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(index, value);
		reg_writes++;
	endtask

	task automatic set_image(input logic comp, input logic four, input logic [24:0] total);
		write_reg(CFG_COMPRESSED, noisy_flag(comp));
		write_reg(CFG_FOUR_BPP, noisy_flag(four));
		write_reg(CFG_PIXEL_TOTAL, total);
	endtask

	task automatic pick_idling();
		case ($urandom_range(3))
			0: begin gap_pct = 0;  gap_max = 1;  stall_pct = 0;  stall_max = 1;  end
			1: begin gap_pct = 20; gap_max = 4;  stall_pct = 20; stall_max = 4;  end
			2: begin gap_pct = 60; gap_max = 12; stall_pct = 60; stall_max = 24; end
			default: begin gap_pct = 0; gap_max = 1; stall_pct = 50; stall_max = 8; end
		endcase
	endtask

	// Valid stays up from one request to the next unless a gap is due
	task automatic send_byte(input logic [7:0] b);
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (image_left != 0)
			live_bytes++;
		decode_byte(b);
	endtask

	task automatic send_stream(input byte_q_t stream);
		int burst_left;
		burst_left = 0;
		foreach (stream[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, gap_max)) @(posedge clk);
				end
			end
			send_byte(stream[i]);
			burst_left--;
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver stall pattern: stall stretches are always followed by a free cycle
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_stall) begin
			out_stall  <= 1'b0;
			stall_hold <= $urandom_range(3);
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			out_stall  <= 1'b1;
			stall_hold <= $urandom_range(stall_max);
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel %02x%02x%02x with none expected",
					red, green, blue));
			end else begin
				want = pending_pixels.pop_front();
				if (red !== want.red)
					report_mismatch($sformatf("red %02x, expected %02x", red, want.red));
				if (green !== want.green)
					report_mismatch($sformatf("green %02x, expected %02x", green, want.green));
				if (blue !== want.blue)
					report_mismatch($sformatf("blue %02x, expected %02x", blue, want.blue));
				if (alpha !== want.alpha)
					report_mismatch($sformatf("alpha %02x, expected %02x", alpha, want.alpha));
				if (repeat_count !== want.span)
					report_mismatch($sformatf("repeat_count %0d, expected %0d",
						repeat_count, want.span));
				if (image_done !== want.done)
					report_mismatch($sformatf("image_done %b, expected %b",
						image_done, want.done));
				pixels_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", quiet_cycles);
			$display("tga_rle_pixel_decoder verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Out of reset: packed, 24-bit, 65536 pixels
	task automatic test_reset_defaults();
		pick_idling();
		send_stream('{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h12, 8'h34, 8'h56});
	endtask

	task automatic test_raw_pixels();
		byte_q_t q;
		pick_idling();
		set_image(1'b0, 1'b1, 25'd2);
		repeat (2) add_random_pixel(q, 1'b1);
		q.push_back(8'hA5);
		send_stream(q);
		q = {};
		write_reg(CFG_FOUR_BPP, noisy_flag(1'b0));
		repeat (2) add_random_pixel(q, 1'b0);
		q.push_back(8'h5A);
		send_stream(q);
	endtask

	task automatic test_run_clipped();
		byte_q_t q;
		pick_idling();
		set_image(1'b1, 1'b1, 25'd3);
		q.push_back(8'h84);
		add_random_pixel(q, 1'b1);
		q.push_back(8'h81);
		send_stream(q);
	endtask

	// Literal packet of 128 pixels in a 2-pixel image: third pixel is dropped
	task automatic test_literal_past_end();
		byte_q_t q;
		pick_idling();
		set_image(1'b1, 1'b0, 25'd2);
		q.push_back(8'h7F);
		repeat (3) add_random_pixel(q, 1'b0);
		send_stream(q);
	endtask

	task automatic test_zero_total();
		pick_idling();
		write_reg(CFG_PIXEL_TOTAL, 25'd0);
		send_stream('{8'hFF, 8'h01, 8'h02, 8'h03});
	endtask

	task automatic test_pixel_total_limits();
		byte_q_t q;
		pick_idling();
		set_image(1'b1, 1'b0, 25'h1FFFFFF);
		q.push_back(8'hFF);
		add_random_pixel(q, 1'b0);
		send_stream(q);
		write_reg(CFG_PIXEL_TOTAL, MAX_PIXEL_COUNT);
		send_stream(q);
		write_reg(CFG_PIXEL_TOTAL, 25'd1);
		q.push_back(8'h00);
		send_stream(q);
	endtask

	// A write to the spare index must not restart the image
	task automatic test_unused_index();
		byte_q_t q;
		pick_idling();
		set_image(1'b1, 1'b0, 25'd4);
		q.push_back(8'h81);
		add_random_pixel(q, 1'b0);
		send_stream(q);
		write_reg(CFG_UNUSED, 25'($urandom));
		send_stream(q);
	endtask

	task automatic test_random_images();
		byte_q_t     q;
		int          start_bytes;
		int          target;
		int          covered;
		int          cnt;
		int          pick;
		logic        comp;
		logic        four;
		logic [24:0] total;
		start_bytes = live_bytes;
		while (live_bytes - start_bytes < RANDOM_ITEMS) begin
			comp = ($urandom_range(9) < 7);
			four = 1'($urandom_range(1));
			pick = $urandom_range(99);
			if (pick < 4)
				total = 25'd0;
			else if (pick < 7)
				total = 25'($urandom_range(33554431, 16777216));
			else if (pick < 8)
				total = MAX_PIXEL_COUNT;
			else
				total = 25'($urandom_range(1, 48));
			if ($urandom_range(15) == 0)
				write_reg(CFG_UNUSED, 25'($urandom));
			set_image(comp, four, total);
			pick_idling();
			target  = (total > 64) ? $urandom_range(1, 64) : int'(total);
			covered = 0;
			q = {};
			while (covered < target) begin
				if (!comp) begin
					add_random_pixel(q, four);
					covered++;
				end else if ($urandom_range(1)) begin
					cnt = ($urandom_range(7) != 0) ? $urandom_range(1, 8)
						: $urandom_range(1, 128);
					q.push_back(8'h80 | 8'(cnt - 1));
					add_random_pixel(q, four);
					covered += cnt;
				end else begin
					cnt = ($urandom_range(29) != 0) ? $urandom_range(1, 5)
						: $urandom_range(1, 128);
					q.push_back(8'(cnt - 1));
					repeat (cnt) add_random_pixel(q, four);
					covered += cnt;
				end
			end
			repeat ($urandom_range(4)) q.push_back(8'($urandom_range(255)));
			// now and then cut the image short mid-packet
			if (q.size() > 1 && $urandom_range(7) == 0)
				q = q[0:$urandom_range(q.size() - 2)];
			send_stream(q);
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_COMPRESSED;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		cfg_compressed  = COMPRESSED_RST;
		cfg_four_bpp    = FOUR_BPP_RST;
		cfg_pixel_total = PIXEL_TOTAL_RST;
		restart_image();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_raw_pixels();
		test_run_clipped();
		test_literal_past_end();
		test_zero_total();
		test_pixel_total_limits();
		test_unused_index();
		test_random_images();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Decoded %0d live bytes into %0d checked pixels over %0d register writes,",
			live_bytes, pixels_checked, reg_writes);
		$display("raw and packed, 24 and 32 bit, with clipped runs and truncated images.");
		if (mismatch_count == 0) begin
			$display("tga_rle_pixel_decoder verification clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("tga_rle_pixel_decoder verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
sv/tgard_pkg.sv
sv/tgard_in_stage.sv
sv/tgard_core.sv
sv/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_decoder_tb.sv
